// File: src/brq_pkg.sv
// shared constants and codes for the byte ring queue
package brq_pkg;

    localparam int DEPTH  = 256;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OP_W   = 2;
    localparam int LEN_W  = 9;
    localparam int BYTE_W = 8;
    localparam int STAT_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 2'd0,
        OP_WRITE   = 2'd1,
        OP_PEEK    = 2'd2,
        OP_CONSUME = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_BUSY    = 3'd2,
        ST_TOOLONG = 3'd3,
        ST_EMPTY   = 3'd4
    } status_t;

endpackage

// File: src/brq_ram.sv
// simple dual port byte store, one write and one registered read per cycle
module brq_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/byte_ring_queue.sv
// top level of the byte ring queue: counter control, result pipeline and byte store
//
//   channel | direction | handshake          | payload
//   input   | in        | in_valid, in_stall | op, length, data_byte
//   result  | out       | out_valid, out_stall | status, used_count, free_count,
//           |           |                    | peek_start, peek_length, peek_byte
//
// one transaction per cycle while out_stall is low; each result passes through
// the intermediate stage, for the registered peek read, and the result register.
// counters update at input acceptance, so the next transaction can follow at once.
// rst_n clears the counters and pipeline valids; the byte store has no reset.
// out_stall holds the result register, and in_stall rises once the
// intermediate stage is also full.
module byte_ring_queue (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [brq_pkg::OP_W-1:0]     op,
    input  logic [brq_pkg::LEN_W-1:0]    length,
    input  logic [brq_pkg::BYTE_W-1:0]   data_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [brq_pkg::STAT_W-1:0]   status,
    output logic [brq_pkg::LEN_W-1:0]    used_count,
    output logic [brq_pkg::LEN_W-1:0]    free_count,
    output logic [brq_pkg::IDX_W-1:0]    peek_start,
    output logic [brq_pkg::LEN_W-1:0]    peek_length,
    output logic [brq_pkg::BYTE_W-1:0]   peek_byte
);

    import brq_pkg::*;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // counter state
    logic [CNT_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] remain_reg, remain_next;

    // intermediate stage, waiting for store read data
    logic             s1_valid_reg;
    status_t          s1_status_reg;
    logic [CNT_W-1:0] s1_used_reg;
    logic [CNT_W-1:0] s1_free_reg;
    logic [IDX_W-1:0] s1_pstart_reg;
    logic [CNT_W-1:0] s1_plen_reg;
    logic             s1_peek_reg;

    // result register
    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [CNT_W-1:0]  out_used_reg;
    logic [CNT_W-1:0]  out_free_reg;
    logic [IDX_W-1:0]  out_pstart_reg;
    logic [CNT_W-1:0]  out_plen_reg;
    logic [BYTE_W-1:0] out_pbyte_reg;

    logic              accept;
    logic              s1_move;
    logic [CNT_W-1:0]  used_now;
    logic [CNT_W-1:0]  free_now;
    logic [CNT_W-1:0]  used_after;
    logic [CNT_W-1:0]  to_end;
    logic [CNT_W-1:0]  pend_inc;
    status_t           status_c;
    logic [IDX_W-1:0]  pstart_c;
    logic [CNT_W-1:0]  plen_c;
    logic              peek_c;
    logic              wr_en;
    logic              rd_en;
    logic [BYTE_W-1:0] rd_data;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    assign used_now = head_reg - tail_reg;
    assign free_now = DEPTH_CNT - used_now;
    assign to_end   = DEPTH_CNT - {1'b0, tail_reg[IDX_W-1:0]};
    assign pend_inc = pend_reg + 1'b1;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        pend_next   = pend_reg;
        remain_next = remain_reg;
        status_c    = ST_OK;
        pstart_c    = '0;
        plen_c      = '0;
        peek_c      = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        if (accept)
        begin
            unique case (op_t'(op))
                OP_RESERVE:
                begin
                    if (remain_reg != '0)
                    begin
                        status_c = ST_BUSY;
                    end
                    else if (length > free_now)
                    begin
                        status_c = ST_NOSPACE;
                    end
                    else if (length != '0)
                    begin
                        pend_next   = head_reg;
                        remain_next = CNT_W'(length);
                    end
                end
                OP_WRITE:
                begin
                    if (remain_reg == '0)
                    begin
                        status_c = ST_BUSY;
                    end
                    else
                    begin
                        wr_en       = 1'b1;
                        pend_next   = pend_inc;
                        remain_next = remain_reg - 1'b1;
                        // last reserved byte publishes the head
                        if (remain_reg == CNT_W'(1))
                        begin
                            head_next = pend_inc;
                        end
                    end
                end
                OP_PEEK:
                begin
                    if (used_now == '0)
                    begin
                        status_c = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        peek_c   = 1'b1;
                        pstart_c = tail_reg[IDX_W-1:0];
                        plen_c   = (used_now < to_end) ? used_now : to_end;
                    end
                end
                OP_CONSUME:
                begin
                    if (length > used_now)
                    begin
                        status_c = ST_TOOLONG;
                    end
                    else
                    begin
                        tail_next = tail_reg + CNT_W'(length);
                    end
                end
                default:
                begin
                    status_c = ST_OK;
                end
            endcase
        end
    end

    assign used_after = head_next - tail_next;

    brq_ram #(
        .DATA_W (BYTE_W),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (pend_reg[IDX_W-1:0]),
        .wr_data (data_byte),
        .rd_en   (rd_en),
        .rd_addr (tail_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            pend_reg      <= '0;
            remain_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            pend_reg   <= pend_next;
            remain_reg <= remain_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status_c;
            s1_used_reg   <= used_after;
            s1_free_reg   <= DEPTH_CNT - used_after;
            s1_pstart_reg <= pstart_c;
            s1_plen_reg   <= plen_c;
            s1_peek_reg   <= peek_c;
        end
        if (s1_move)
        begin
            out_status_reg <= s1_status_reg;
            out_used_reg   <= s1_used_reg;
            out_free_reg   <= s1_free_reg;
            out_pstart_reg <= s1_pstart_reg;
            out_plen_reg   <= s1_plen_reg;
            out_pbyte_reg  <= s1_peek_reg ? rd_data : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign used_count  = out_used_reg;
    assign free_count  = out_free_reg;
    assign peek_start  = out_pstart_reg;
    assign peek_length = out_plen_reg;
    assign peek_byte   = out_pbyte_reg;

endmodule
